[hw/rtl/olir_pkg.sv]
package olir_pkg;

	localparam int DEF_CAPACITY   = 256;
	localparam int DEF_ITEM_WIDTH = 32;
	localparam int CAPACITY_LIMIT = 16384;

	typedef enum logic [1:0] {
		CMD_READ   = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_POP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_APPLY,
		ST_DRAIN,
		ST_REPLY
	} state_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic apply;
		logic ins;
		logic rem;
		logic take;
	} cell_ctl_t;

	// register stages from the cell taps to the tree root
	function automatic int tree_latency(input int leaves);
		int depth;
		begin
			depth = $clog2(leaves);
			return 1 + (depth - 1) / 4;
		end
	endfunction

endpackage

[hw/rtl/olir_cell.sv]
module olir_cell #(
	parameter int CAPACITY   = olir_pkg::DEF_CAPACITY,
	parameter int ITEM_WIDTH = olir_pkg::DEF_ITEM_WIDTH,
	parameter int INDEX      = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  olir_pkg::cell_ctl_t           ctl,
	input  logic [$clog2(CAPACITY)-1:0]   pos,
	input  logic [ITEM_WIDTH-1:0]         item,
	input  logic [ITEM_WIDTH-1:0]         lower,
	input  logic [ITEM_WIDTH-1:0]         upper,
	output logic [ITEM_WIDTH-1:0]         word,
	output logic [ITEM_WIDTH-1:0]         tap
);
	import olir_pkg::*;

	localparam int PW = $clog2(CAPACITY);
	localparam logic [PW-1:0] MY_POS = PW'(INDEX);

	logic [ITEM_WIDTH-1:0] word_q;
	logic [ITEM_WIDTH-1:0] tap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (ctl.ins) begin
			if (MY_POS > pos) begin
				word_q <= lower;
			end else if (MY_POS == pos) begin
				word_q <= item;
			end
		end else if (ctl.rem) begin
			if (MY_POS >= pos) begin
				word_q <= upper;
			end
		end
	end

	// value seen before the shift
	always_ff @(posedge clk) begin
		if (ctl.apply) begin
			tap_q <= (ctl.take && MY_POS == pos) ? word_q : '0;
		end
	end

	assign word = word_q;
	assign tap  = tap_q;

endmodule

[hw/rtl/olir_or_tree.sv]
module olir_or_tree #(
	parameter int LEAVES = olir_pkg::DEF_CAPACITY,
	parameter int WIDTH  = olir_pkg::DEF_ITEM_WIDTH
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] leaf [LEAVES],
	output logic [WIDTH-1:0] root
);
	import olir_pkg::*;

	localparam int DEPTH = $clog2(LEAVES);
	localparam int P     = 1 << DEPTH;

	logic [WIDTH-1:0] node_w [2*P-1];

	for (genvar i = 0; i < P; i++) begin : g_leaf
		if (i < LEAVES) begin : g_used
			assign node_w[P-1+i] = leaf[i];
		end else begin : g_pad
			assign node_w[P-1+i] = '0;
		end
	end

	for (genvar n = 0; n < P - 1; n++) begin : g_node
		localparam int LVL = $clog2(n + 2) - 1;
		logic [WIDTH-1:0] sum_w;
		assign sum_w = node_w[2*n+1] | node_w[2*n+2];
		if (LVL == 0 || ((DEPTH - LVL) % 4) == 0) begin : g_reg
			logic [WIDTH-1:0] sum_q;
			always_ff @(posedge clk) begin
				sum_q <= sum_w;
			end
			assign node_w[n] = sum_q;
		end else begin : g_comb
			assign node_w[n] = sum_w;
		end
	end

	assign root = node_w[0];

endmodule

[hw/rtl/ordered_list_insert_remove.sv]
// channel   dir  handshake               payload
// command   in   start, busy             command[1:0] index[7:0] item[31:0]
// result    out  done                    item_out[31:0] length_out[8:0] status[1:0]
//
// the accepted command passes the states apply, drain and reply, and done beats in reply;
// L = 1 + (log2(CAPACITY)-1)/4 is the register depth of the or tree that collects the
// addressed cell, and drain waits for it; the whole cell chain shifts at once in apply;
// busy is high after the accept edge through the done cycle, and no command is taken meanwhile
// reset clears the stored word of every cell and the length at once
// the receiver cannot stall: a done beat is taken in the cycle it is shown
module ordered_list_insert_remove #(
	parameter int CAPACITY   = olir_pkg::DEF_CAPACITY,
	parameter int ITEM_WIDTH = olir_pkg::DEF_ITEM_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [7:0]  index,
	input  logic [31:0] item,
	output logic        done,
	output logic [31:0] item_out,
	output logic [8:0]  length_out,
	output logic [1:0]  status
);
	import olir_pkg::*;

	localparam int PW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > 8) ? CW : 8;
	localparam int LAT  = tree_latency(CAPACITY);
	localparam int RW   = $clog2(LAT + 1);

	state_t                state_q, state_d;
	cmd_t                  cmd_q;
	logic [7:0]            idx_q;
	logic [ITEM_WIDTH-1:0] item_q;
	logic [CW-1:0]         count_q;
	status_t               status_q;
	logic [RW-1:0]         wait_q;

	logic                  accept;
	logic                  ok;
	logic [PW-1:0]         pos;
	logic                  in_range;
	cell_ctl_t             ctl;
	status_t               status_d;

	logic [ITEM_WIDTH-1:0] word_w [CAPACITY];
	logic [ITEM_WIDTH-1:0] tap_w  [CAPACITY];
	logic [ITEM_WIDTH-1:0] root_w;

	assign accept   = start && !busy;
	assign in_range = CMPW'(idx_q) < CMPW'(count_q);

	always_comb begin
		ok  = 1'b0;
		pos = PW'(idx_q);
		case (cmd_q)
			CMD_READ, CMD_REMOVE: begin
				ok = in_range;
			end
			CMD_INSERT: begin
				ok  = count_q != CW'(CAPACITY);
				pos = in_range ? PW'(idx_q) : PW'(count_q);
			end
			CMD_POP: begin
				ok  = count_q != '0;
				pos = PW'(count_q - CW'(1));
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		if (ok) begin
			status_d = STAT_OK;
		end else if (cmd_q == CMD_INSERT) begin
			status_d = STAT_FULL;
		end else begin
			status_d = STAT_RANGE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		busy      = 1'b1;
		done      = 1'b0;
		ctl       = '0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				ctl.apply = 1'b1;
				ctl.ins   = ok && cmd_q == CMD_INSERT;
				ctl.rem   = ok && (cmd_q == CMD_REMOVE || cmd_q == CMD_POP);
				ctl.take  = ok && cmd_q != CMD_INSERT;
				state_d   = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (wait_q == RW'(1)) begin
					state_d = ST_REPLY;
				end
			end
			ST_REPLY: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd_t'(command);
			idx_q  <= index;
			item_q <= ITEM_WIDTH'(item);
		end
		if (ctl.apply) begin
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wait_q  <= '0;
		end else begin
			if (ctl.ins) begin
				count_q <= count_q + CW'(1);
			end else if (ctl.rem) begin
				count_q <= count_q - CW'(1);
			end
			if (ctl.apply) begin
				wait_q <= RW'(LAT);
			end else if (state_q == ST_DRAIN) begin
				wait_q <= wait_q - RW'(1);
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ITEM_WIDTH-1:0] lower_w;
		logic [ITEM_WIDTH-1:0] upper_w;
		if (i == 0) begin : g_first
			assign lower_w = '0;
		end else begin : g_lower
			assign lower_w = word_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign upper_w = '0;
		end else begin : g_upper
			assign upper_w = word_w[i+1];
		end
		olir_cell #(
			.CAPACITY  (CAPACITY),
			.ITEM_WIDTH(ITEM_WIDTH),
			.INDEX     (i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.pos   (pos),
			.item  (item_q),
			.lower (lower_w),
			.upper (upper_w),
			.word  (word_w[i]),
			.tap   (tap_w[i])
		);
	end

	olir_or_tree #(
		.LEAVES(CAPACITY),
		.WIDTH (ITEM_WIDTH)
	) u_tree (
		.clk (clk),
		.leaf(tap_w),
		.root(root_w)
	);

	assign item_out   = 32'(root_w);
	assign length_out = 9'(count_q);
	assign status     = status_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("length beyond capacity");

	a_len_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> (count_q == $past(count_q) + CW'(1)
			|| count_q == $past(count_q) - CW'(1)))
		else $error("length moved by more than one");

	a_len_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_APPLY |=> $stable(count_q))
		else $error("length changed outside apply");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != STAT_OK |-> item_out == '0)
		else $error("failed command returned an item");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done beat while not busy");

endmodule
